### src/rbs_pkg.sv
// Shared constants and types of the ray versus box slab test.
`timescale 1ns / 1ps

package rbs_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;

   localparam int CSR_INDEX_WIDTH = 3;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type CSR_ORIGIN_X  = 3'd0;
   localparam csr_index_type CSR_ORIGIN_Y  = 3'd1;
   localparam csr_index_type CSR_ORIGIN_Z  = 3'd2;
   localparam csr_index_type CSR_INV_DIR_X = 3'd3;
   localparam csr_index_type CSR_INV_DIR_Y = 3'd4;
   localparam csr_index_type CSR_INV_DIR_Z = 3'd5;

   localparam int NUM_AXES = 3;

endpackage

### src/rbs_if.sv
// Valid/ready channel interfaces for box items and hit results.
`timescale 1ns / 1ps

interface rbs_req_if #(
   parameter int COORD_WIDTH = rbs_pkg::COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] lower_x;
   logic signed [COORD_WIDTH-1:0] lower_y;
   logic signed [COORD_WIDTH-1:0] lower_z;
   logic signed [COORD_WIDTH-1:0] upper_x;
   logic signed [COORD_WIDTH-1:0] upper_y;
   logic signed [COORD_WIDTH-1:0] upper_z;
   logic signed [COORD_WIDTH-1:0] interval_start;
   logic signed [COORD_WIDTH-1:0] interval_end;

   modport source (
      output valid, lower_x, lower_y, lower_z, upper_x, upper_y, upper_z,
             interval_start, interval_end,
      input  ready
   );
   modport sink (
      input  valid, lower_x, lower_y, lower_z, upper_x, upper_y, upper_z,
             interval_start, interval_end,
      output ready
   );
endinterface

interface rbs_rsp_if #(
   parameter int COORD_WIDTH = rbs_pkg::COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic signed [COORD_WIDTH-1:0] entry_distance;

   modport source (
      output valid, hit, entry_distance,
      input  ready
   );
   modport sink (
      input  valid, hit, entry_distance,
      output ready
   );
endinterface

### src/ray_box_slab_test.sv
// Ray versus axis-aligned box test by the slab method: five-stage pipeline.
//
// The ray origin and per-axis inverse direction sit in registers written over
// the csr_ port (index 0..2 origin x/y/z, 3..5 inverse direction x/y/z), signed
// fixed point with FRAC_BITS fraction bits. Write them only while no item is in
// flight. Each item on req_chan carries a box (lower and upper corners) and a
// distance interval; rsp_chan returns one item per box: hit, and the entry
// distance on a hit or 0 on a miss.
// Results pass through five register stages (plane select and difference,
// multiply, floor shift and saturation, x/y narrowing, z narrowing with interval
// test) before they are valid on rsp_chan. Throughput: one box per cycle while rsp_chan
// does not stall, set by the single multiplier per slab plane in the multiply stage.
// Each stage holds while the stage after it is full and blocked, so a stall on
// rsp_chan backs up stage by stage; nothing is dropped or repeated, and bubbles
// are squeezed out. Reset (synchronous) empties the pipeline, clears the
// origin to 0 and sets the inverse direction to 1.0 on every axis.
`timescale 1ns / 1ps

module ray_box_slab_test #(
   parameter int COORD_WIDTH = rbs_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = rbs_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   rbs_req_if.sink                     req_chan,
   rbs_rsp_if.source                   rsp_chan,
   input  logic                        csr_we,
   input  rbs_pkg::csr_index_type      csr_index,
   input  logic [COORD_WIDTH-1:0]      csr_wdata
);
   import rbs_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int PW = 2 * COORD_WIDTH + 1;
   localparam logic [W-1:0] ONE_VAL =
      (FRAC_BITS < W) ? (W'(1) << FRAC_BITS) : '0;

   typedef logic signed [W-1:0]  coord_type;
   typedef logic signed [W:0]    diff_type;
   typedef logic signed [PW-1:0] prod_type;

   function automatic coord_type sat_shift(input prod_type p);
      prod_type sh;
      logic     over_pos;
      logic     over_neg;
      sh       = p >>> FRAC_BITS;
      over_pos = !sh[PW-1] && (|sh[PW-1:W-1]);
      over_neg = sh[PW-1] && !(&sh[PW-1:W-1]);
      if (over_pos) begin
         return {1'b0, {(W-1){1'b1}}};
      end else if (over_neg) begin
         return {1'b1, {(W-1){1'b0}}};
      end
      return sh[W-1:0];
   endfunction

   // configuration
   coord_type origin_ff [NUM_AXES];
   coord_type inv_ff    [NUM_AXES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_AXES; k++) begin
            origin_ff[k] <= '0;
            inv_ff[k]    <= ONE_VAL;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ORIGIN_X:  origin_ff[0] <= csr_wdata;
            CSR_ORIGIN_Y:  origin_ff[1] <= csr_wdata;
            CSR_ORIGIN_Z:  origin_ff[2] <= csr_wdata;
            CSR_INV_DIR_X: inv_ff[0]    <= csr_wdata;
            CSR_INV_DIR_Y: inv_ff[1]    <= csr_wdata;
            CSR_INV_DIR_Z: inv_ff[2]    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage valids and enables
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic en1, en2, en3, en4, en5;

   assign en5 = !s5_valid_ff || rsp_chan.ready;
   assign en4 = !s4_valid_ff || en5;
   assign en3 = !s3_valid_ff || en4;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;
   assign req_chan.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (en1) s1_valid_ff <= req_chan.valid;
         if (en2) s2_valid_ff <= s1_valid_ff;
         if (en3) s3_valid_ff <= s2_valid_ff;
         if (en4) s4_valid_ff <= s3_valid_ff;
         if (en5) s5_valid_ff <= s4_valid_ff;
      end
   end

   // stage 1: plane select and exact difference
   coord_type lower [NUM_AXES];
   coord_type upper [NUM_AXES];
   diff_type  dn1_in [NUM_AXES];
   diff_type  df1_in [NUM_AXES];
   diff_type  dn1_ff [NUM_AXES];
   diff_type  df1_ff [NUM_AXES];
   coord_type t0_1_ff, t1_1_ff;

   assign lower[0] = req_chan.lower_x;
   assign lower[1] = req_chan.lower_y;
   assign lower[2] = req_chan.lower_z;
   assign upper[0] = req_chan.upper_x;
   assign upper[1] = req_chan.upper_y;
   assign upper[2] = req_chan.upper_z;

   always_comb begin
      for (int k = 0; k < NUM_AXES; k++) begin
         if (inv_ff[k][W-1]) begin
            dn1_in[k] = diff_type'(upper[k]) - diff_type'(origin_ff[k]);
            df1_in[k] = diff_type'(lower[k]) - diff_type'(origin_ff[k]);
         end else begin
            dn1_in[k] = diff_type'(lower[k]) - diff_type'(origin_ff[k]);
            df1_in[k] = diff_type'(upper[k]) - diff_type'(origin_ff[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         dn1_ff  <= dn1_in;
         df1_ff  <= df1_in;
         t0_1_ff <= req_chan.interval_start;
         t1_1_ff <= req_chan.interval_end;
      end
   end

   // stage 2: exact products
   prod_type  pn2_ff [NUM_AXES];
   prod_type  pf2_ff [NUM_AXES];
   coord_type t0_2_ff, t1_2_ff;

   always_ff @(posedge clock) begin
      if (en2) begin
         for (int k = 0; k < NUM_AXES; k++) begin
            pn2_ff[k] <= prod_type'(dn1_ff[k]) * prod_type'(inv_ff[k]);
            pf2_ff[k] <= prod_type'(df1_ff[k]) * prod_type'(inv_ff[k]);
         end
         t0_2_ff <= t0_1_ff;
         t1_2_ff <= t1_1_ff;
      end
   end

   // stage 3: floor shift and saturation
   coord_type tn3_ff [NUM_AXES];
   coord_type tf3_ff [NUM_AXES];
   coord_type t0_3_ff, t1_3_ff;

   always_ff @(posedge clock) begin
      if (en3) begin
         for (int k = 0; k < NUM_AXES; k++) begin
            tn3_ff[k] <= sat_shift(pn2_ff[k]);
            tf3_ff[k] <= sat_shift(pf2_ff[k]);
         end
         t0_3_ff <= t0_2_ff;
         t1_3_ff <= t1_2_ff;
      end
   end

   // stage 4: narrow over x and y
   coord_type tmin4_ff, tmax4_ff, tnz4_ff, tfz4_ff, t0_4_ff, t1_4_ff;
   logic      miss4_ff;

   always_ff @(posedge clock) begin
      if (en4) begin
         miss4_ff <= (tn3_ff[1] > tf3_ff[0]) || (tn3_ff[0] > tf3_ff[1]);
         tmin4_ff <= (tn3_ff[1] > tn3_ff[0]) ? tn3_ff[1] : tn3_ff[0];
         tmax4_ff <= (tf3_ff[1] < tf3_ff[0]) ? tf3_ff[1] : tf3_ff[0];
         tnz4_ff  <= tn3_ff[2];
         tfz4_ff  <= tf3_ff[2];
         t0_4_ff  <= t0_3_ff;
         t1_4_ff  <= t1_3_ff;
      end
   end

   // stage 5: narrow over z, interval test, output register
   logic      miss5, hit5_in;
   coord_type tmin5, tmax5;
   logic      hit_ff;
   coord_type entry_ff;

   always_comb begin
      miss5   = miss4_ff || (tnz4_ff > tmax4_ff) || (tmin4_ff > tfz4_ff);
      tmin5   = (tnz4_ff > tmin4_ff) ? tnz4_ff : tmin4_ff;
      tmax5   = (tfz4_ff < tmax4_ff) ? tfz4_ff : tmax4_ff;
      hit5_in = !miss5 && (tmin5 < t1_4_ff) && (tmax5 > t0_4_ff);
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         hit_ff   <= hit5_in;
         entry_ff <= hit5_in ? tmin5 : '0;
      end
   end

   assign rsp_chan.valid          = s5_valid_ff;
   assign rsp_chan.hit            = hit_ff;
   assign rsp_chan.entry_distance = entry_ff;

   // checks
   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> s1_valid_ff)
      else $error("accepted item did not enter stage 1");

   a_stage1_holds : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !en2 |=> s1_valid_ff && $stable(t0_1_ff) && $stable(t1_1_ff))
      else $error("stalled stage 1 lost its item");

   a_xy_miss_final : assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff && miss4_ff && en5 |=> !hit_ff)
      else $error("x/y slab miss reported as hit");

   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.hit |-> rsp_chan.entry_distance == '0)
      else $error("miss carries nonzero entry distance");

   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_valid_ff && s3_valid_ff && s4_valid_ff && s5_valid_ff
      && !rsp_chan.ready |-> !req_chan.ready)
      else $error("full pipeline took an item while output stalled");

endmodule
